@@ src/ops_pkg.sv @@
// ----------------------------------------------------------------------------
// ops_pkg: shared definitions for the outline point stream splitter
// Widths, run store geometry, register indexes and the squaring unit command.
// ----------------------------------------------------------------------------
package ops_pkg;

  // Run store geometry.
  localparam int CORNER_CAP = 16;
  localparam int RUN_DEPTH  = CORNER_CAP + 1;
  localparam int IDX_W      = $clog2(RUN_DEPTH);
  localparam int LEN_W      = $clog2(CORNER_CAP + 2);
  localparam int MIN_POLY   = 3;

  // Field widths.
  localparam int COORD_W  = 32;
  localparam int POINT_W  = 3 * COORD_W;
  localparam int NUM_W    = 5;
  localparam int RADIUS_W = 16;
  localparam int LIMIT_W  = 5;
  localparam int IN_DATA_W  = 96;
  localparam int OUT_DATA_W = 104;

  // Squaring unit widths.
  localparam int SQ_W   = 16;
  localparam int PROD_W = 2 * SQ_W;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLOSE_RADIUS = 1'b0,
    CFG_CORNER_LIMIT = 1'b1
  } cfg_index_t;

  localparam logic [RADIUS_W-1:0] CLOSE_RADIUS_RESET = 16'd256;
  localparam logic [LIMIT_W-1:0]  CORNER_LIMIT_RESET = 5'd16;

  // Input opcodes carried in the slave tuser.
  localparam logic OP_POINT = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // Command to the shared squaring unit.
  typedef struct packed {
    logic            en;
    logic [SQ_W-1:0] operand;
  } sq_cmd_t;

endpackage

@@ src/outline_point_stream_splitter_top.sv @@
// ----------------------------------------------------------------------------
// outline_point_stream_splitter_top: cuts a corner point stream into polygons
// Sequence: a corner point has the radius squared, then each stored corner is
// scanned (read, difference, two squarings, compare), and the point is appended.
// A new request is taken only in idle, once the previous one is done; an emitted
// polygon is read out corner by corner while the output is drained.
// Reset: synchronous; clears the run length and handshakes, loads register defaults.
// ----------------------------------------------------------------------------
module outline_point_stream_splitter_top (
  input  logic                               clk,
  input  logic                               rst,
  // Configuration write channel.
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ops_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ops_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Input points.
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [ops_pkg::IN_DATA_W-1:0]      s_tdata,  // point_x, point_y, point_z
  input  logic                               s_tuser,  // opcode
  // Output corners.
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // corner_x, corner_y, corner_z, corner_number, zero fill
  output logic [ops_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                               m_tlast,  // last_corner
  output logic                               m_tuser   // unclosed
);

  localparam int CW = ops_pkg::COORD_W;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RSQ,
    S_RSQW,
    S_RD,
    S_DIF,
    S_SQX,
    S_SQY,
    S_CMP,
    S_APP,
    S_EMRD,
    S_EMLD
  } state_t;

  state_t state;

  logic [ops_pkg::RADIUS_W-1:0] close_radius;
  logic [ops_pkg::LIMIT_W-1:0]  corner_limit;
  logic [ops_pkg::LEN_W-1:0]    run_len;
  logic [ops_pkg::LEN_W-1:0]    idx;
  logic [ops_pkg::LEN_W-1:0]    limit;
  logic [CW-1:0]                px, py, pz;
  logic [ops_pkg::PROD_W-1:0]   rsq;
  logic [ops_pkg::PROD_W-1:0]   sumx;
  logic [ops_pkg::SQ_W-1:0]     adx, ady;
  logic                         far;
  logic [ops_pkg::IDX_W-1:0]    em_idx, em_end, em_base;
  logic                         em_unclosed;

  logic                         ram_we, ram_re;
  logic [ops_pkg::IDX_W-1:0]    ram_raddr;
  logic [ops_pkg::POINT_W-1:0]  ram_rdata;
  ops_pkg::sq_cmd_t             sq_cmd;
  logic [ops_pkg::PROD_W-1:0]   sq_prod;

  logic signed [CW:0]           dx, dy;
  logic [CW:0]                  mag_x, mag_y;
  logic [ops_pkg::PROD_W:0]     dist_sq;
  logic                         close_hit;
  logic [ops_pkg::LEN_W-1:0]    tail_cnt;
  logic                         out_free;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign out_free  = !m_tvalid || m_tready;

  // Saturate the corner limit at the store capacity.
  always_comb begin
    if (32'(corner_limit) > 32'(ops_pkg::CORNER_CAP)) begin
      limit = ops_pkg::LEN_W'(ops_pkg::CORNER_CAP);
    end else begin
      limit = ops_pkg::LEN_W'(corner_limit);
    end
  end

  // Planar difference against the stored corner just read.
  always_comb begin
    dx    = $signed({px[CW-1], px}) - $signed({ram_rdata[CW-1], ram_rdata[CW-1:0]});
    dy    = $signed({py[CW-1], py}) -
            $signed({ram_rdata[2*CW-1], ram_rdata[2*CW-1:CW]});
    mag_x = dx[CW] ? (CW+1)'(-dx) : (CW+1)'(dx);
    mag_y = dy[CW] ? (CW+1)'(-dy) : (CW+1)'(dy);
  end

  // Distance compare: the second square arrives from the unit in S_CMP.
  assign dist_sq   = {1'b0, sumx} + {1'b0, sq_prod};
  assign close_hit = !far && (dist_sq < {1'b0, rsq});
  assign tail_cnt  = run_len - idx;

  // Store and squaring unit control.
  always_comb begin
    ram_we         = (state == S_APP);
    ram_re         = (state == S_RD) || (state == S_EMRD);
    ram_raddr      = (state == S_RD) ? idx[ops_pkg::IDX_W-1:0] : em_idx;
    sq_cmd.en      = (state == S_RSQ) || (state == S_SQX) || (state == S_SQY);
    sq_cmd.operand = close_radius;
    if (state == S_SQX) begin
      sq_cmd.operand = adx;
    end else if (state == S_SQY) begin
      sq_cmd.operand = ady;
    end
  end

  ops_ram #(
    .WIDTH(ops_pkg::POINT_W),
    .DEPTH(ops_pkg::RUN_DEPTH)
  ) u_run_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(run_len[ops_pkg::IDX_W-1:0]),
    .wdata({pz, py, px}),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  ops_sq_unit u_sq (
    .clk (clk),
    .cmd (sq_cmd),
    .prod(sq_prod)
  );

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      close_radius <= ops_pkg::CLOSE_RADIUS_RESET;
      corner_limit <= ops_pkg::CORNER_LIMIT_RESET;
      run_len      <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          ops_pkg::CFG_CLOSE_RADIUS: close_radius <= cfg_data;
          ops_pkg::CFG_CORNER_LIMIT: corner_limit <= cfg_data[ops_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end

      // A taken corner is released unless the next one is loaded right away.
      if (m_tvalid && m_tready && state != S_EMLD) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            px  <= s_tdata[CW-1:0];
            py  <= s_tdata[2*CW-1:CW];
            pz  <= s_tdata[3*CW-1:2*CW];
            idx <= '0;
            if (s_tuser == ops_pkg::OP_FLUSH) begin
              // End of list flushes a run of three or more.
              run_len     <= '0;
              em_idx      <= '0;
              em_base     <= '0;
              em_end      <= ops_pkg::IDX_W'(run_len - 1'b1);
              em_unclosed <= 1'b1;
              state       <= (32'(run_len) >= 32'(ops_pkg::MIN_POLY)) ? S_EMRD : S_IDLE;
            end else begin
              state <= S_RSQ;
            end
          end
        end
        S_RSQ: begin
          state <= S_RSQW;
        end
        S_RSQW: begin
          rsq   <= sq_prod;
          state <= (run_len == '0) ? S_APP : S_RD;
        end
        S_RD: begin
          state <= S_DIF;
        end
        S_DIF: begin
          adx   <= mag_x[ops_pkg::SQ_W-1:0];
          ady   <= mag_y[ops_pkg::SQ_W-1:0];
          far   <= (|mag_x[CW:ops_pkg::SQ_W]) || (|mag_y[CW:ops_pkg::SQ_W]);
          state <= S_SQX;
        end
        S_SQX: begin
          state <= S_SQY;
        end
        S_SQY: begin
          sumx  <= sq_prod;
          state <= S_CMP;
        end
        S_CMP: begin
          if (close_hit) begin
            // Closed: emit from the matching corner on, if long enough.
            run_len     <= '0;
            em_idx      <= idx[ops_pkg::IDX_W-1:0];
            em_base     <= idx[ops_pkg::IDX_W-1:0];
            em_end      <= ops_pkg::IDX_W'(run_len - 1'b1);
            em_unclosed <= 1'b0;
            state <= (32'(tail_cnt) >= 32'(ops_pkg::MIN_POLY)) ? S_EMRD : S_IDLE;
          end else if (idx + 1'b1 == run_len) begin
            state <= S_APP;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        S_APP: begin
          // The point is written this cycle; flush the run if it is over limit.
          if (run_len + 1'b1 > limit) begin
            run_len     <= '0;
            em_idx      <= '0;
            em_base     <= '0;
            em_end      <= run_len[ops_pkg::IDX_W-1:0];
            em_unclosed <= 1'b1;
            state       <= S_EMRD;
          end else begin
            run_len <= run_len + 1'b1;
            state   <= S_IDLE;
          end
        end
        S_EMRD: begin
          state <= S_EMLD;
        end
        S_EMLD: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b000, ops_pkg::NUM_W'(em_idx - em_base), ram_rdata};
            m_tlast  <= (em_idx == em_end);
            m_tuser  <= em_unclosed;
            em_idx   <= em_idx + 1'b1;
            state    <= (em_idx == em_end) ? S_IDLE : S_EMRD;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The run never grows past the store capacity between requests.
  a_len_cap: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> 32'(run_len) <= 32'(ops_pkg::CORNER_CAP))
    else $error("run length above capacity");

  // An end-of-list request always leaves an empty run.
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == ops_pkg::OP_FLUSH |=> run_len == '0)
    else $error("end of list did not clear the run");

  // A closed polygon ends on its third corner or later.
  a_closed_len: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast && !m_tuser |-> m_tdata[100:96] >= 5'd2)
    else $error("closed polygon shorter than three corners");

  // Emission never walks past the last corner of the polygon.
  a_em_range: assert property (@(posedge clk) disable iff (rst)
    state == S_EMRD || state == S_EMLD |-> em_idx <= em_end)
    else $error("emission index past the end");

endmodule

@@ src/ops_ram.sv @@
// ----------------------------------------------------------------------------
// ops_ram: generic single write, single read RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module ops_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/ops_sq_unit.sv @@
// ----------------------------------------------------------------------------
// ops_sq_unit: shared squaring unit
// Squares a 16-bit magnitude; the product is registered and valid in the cycle
// after the command.
// ----------------------------------------------------------------------------
module ops_sq_unit (
  input  logic                      clk,
  input  ops_pkg::sq_cmd_t          cmd,
  output logic [ops_pkg::PROD_W-1:0] prod
);

  // Registered product, held until the next command.
  always_ff @(posedge clk) begin
    if (cmd.en) begin
      prod <= ops_pkg::PROD_W'(cmd.operand) * ops_pkg::PROD_W'(cmd.operand);
    end
  end

endmodule
